[src/ray_sphere_intersect_defines.svh]
// Assertion macros shared by the ray and sphere intersection block.
`ifndef RAY_SPHERE_INTERSECT_DEFINES_SVH
`define RAY_SPHERE_INTERSECT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RSI_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ray_sphere_intersect: check failed");

// The consequent must hold in the cycle after the antecedent.
`define RSI_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ray_sphere_intersect: check failed");

`endif

[src/rsi_pkg.sv]
`timescale 1ns / 1ps

package rsi_pkg;

    localparam int CoordW  = 32;
    localparam int DirW    = 18;
    localparam int RadiusW = 31;
    localparam int DistW   = 31;
    localparam int CfgIdxW = 8;
    localparam int CfgDataW = 32;

    localparam logic [RadiusW-1:0] RadiusReset = 31'd65536;

    typedef enum logic [CfgIdxW-1:0] {
        REG_CENTRE_X      = 8'd0,
        REG_CENTRE_Y      = 8'd1,
        REG_CENTRE_Z      = 8'd2,
        REG_SPHERE_RADIUS = 8'd3
    } cfg_idx_t;

endpackage

[src/rsi_if.sv]
`timescale 1ns / 1ps

interface rsi_ray_if;
    import rsi_pkg::*;
    logic                      valid;
    logic                      ready;
    logic signed [CoordW-1:0]  origin_x;
    logic signed [CoordW-1:0]  origin_y;
    logic signed [CoordW-1:0]  origin_z;
    logic signed [DirW-1:0]    dir_x;
    logic signed [DirW-1:0]    dir_y;
    logic signed [DirW-1:0]    dir_z;

    modport source (output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                    input ready);
    modport sink (input valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                  output ready);
endinterface

interface rsi_res_if;
    import rsi_pkg::*;
    logic             valid;
    logic             ready;
    logic             hit;
    logic [DistW-1:0] hit_distance;

    modport source (output valid, hit, hit_distance, input ready);
    modport sink (input valid, hit, hit_distance, output ready);
endinterface

interface rsi_cfg_if;
    import rsi_pkg::*;
    logic                valid;
    logic                ready;
    logic [CfgIdxW-1:0]  index;
    logic [CfgDataW-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

[src/ray_sphere_intersect.sv]
// Ray against sphere intersection, one ray per clock unless stalled.
// Channels: ray (sink) carries a ray origin in signed Q16.16 and a direction
// in signed Q1.16; result (source) carries hit and hit_distance in unsigned Q15.16;
// cfg (sink) writes the sphere centre and radius by register index.
// A cfg word is always taken; it must only be written while no ray is in flight.
// From an accepted ray word to its result word a ray passes through
// six arithmetic stages, a 52-stage square root that resolves one root bit
// per stage, and the output register.
// One ray per cycle unless stalled; the square root is fully pipelined.
// All stages advance together when the output register is empty or taken.
// If the receiver stalls, the whole pipeline holds and ray.ready drops;
// nothing is lost or repeated.
// Reset clears all valid bits, the centre to zero and the radius to 1.0.
`timescale 1ns / 1ps

`include "ray_sphere_intersect_defines.svh"

module ray_sphere_intersect (
    input  logic       clk,
    input  logic       rst_n,
    rsi_ray_if.sink    ray,
    rsi_res_if.source  result,
    rsi_cfg_if.sink    cfg
);
    import rsi_pkg::*;

    localparam int SqN = 52;

    logic signed [CoordW-1:0]  centre_x_reg, centre_y_reg, centre_z_reg;
    logic        [RadiusW-1:0] radius_reg;
    logic                      en;

    logic                      v1_reg;
    logic signed [32:0]        lx1_reg, ly1_reg, lz1_reg;
    logic signed [DirW-1:0]    dx1_reg, dy1_reg, dz1_reg;

    logic                      v2_reg;
    logic signed [50:0]        px2_reg, py2_reg, pz2_reg;
    logic        [63:0]        sx2_reg, sy2_reg, sz2_reg;
    logic        [61:0]        r2_reg;
    logic        [31:0]        ux_next, uy_next, uz_next;

    logic                      v3_reg;
    logic signed [51:0]        b3_reg;
    logic        [65:0]        ll3_reg;

    logic                      v4_reg;
    logic signed [51:0]        b4_reg;
    logic        [65:0]        ll4_reg;
    logic        [51:0]        aa4_reg;
    logic        [50:0]        am4_reg;
    logic        [49:0]        hh4_reg;
    logic        [50:0]        ab_next;

    logic                      v5_reg;
    logic signed [51:0]        b5_reg;
    logic        [103:0]       pos5_reg, neg5_reg;

    logic                      sv_reg   [0:SqN];
    logic                      smiss_reg[0:SqN];
    logic signed [51:0]        sb_reg   [0:SqN];
    logic        [103:0]       sdisc_reg[0:SqN];
    logic        [51:0]        sroot_reg[0:SqN];
    logic        [54:0]        srem_reg [0:SqN];

    logic                      vo_reg;
    logic                      hit_reg;
    logic        [DistW-1:0]   dist_reg;
    logic                      hit_next;
    logic        [DistW-1:0]   dist_next;

    assign en        = !vo_reg || result.ready;
    assign ray.ready = en;
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            centre_x_reg <= '0;
            centre_y_reg <= '0;
            centre_z_reg <= '0;
            radius_reg   <= RadiusReset;
        end
        else if (cfg.valid)
        begin
            unique case (cfg_idx_t'(cfg.index))
                REG_CENTRE_X:      centre_x_reg <= cfg.data;
                REG_CENTRE_Y:      centre_y_reg <= cfg.data;
                REG_CENTRE_Z:      centre_z_reg <= cfg.data;
                REG_SPHERE_RADIUS: radius_reg   <= cfg.data[RadiusW-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        ux_next = lx1_reg[32] ? 32'(-lx1_reg) : lx1_reg[31:0];
        uy_next = ly1_reg[32] ? 32'(-ly1_reg) : ly1_reg[31:0];
        uz_next = lz1_reg[32] ? 32'(-lz1_reg) : lz1_reg[31:0];
        ab_next = b3_reg[51] ? 51'(-b3_reg) : b3_reg[50:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= ray.valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lx1_reg <= 33'(ray.origin_x) - 33'(centre_x_reg);
            ly1_reg <= 33'(ray.origin_y) - 33'(centre_y_reg);
            lz1_reg <= 33'(ray.origin_z) - 33'(centre_z_reg);
            dx1_reg <= ray.dir_x;
            dy1_reg <= ray.dir_y;
            dz1_reg <= ray.dir_z;

            px2_reg <= dx1_reg * lx1_reg;
            py2_reg <= dy1_reg * ly1_reg;
            pz2_reg <= dz1_reg * lz1_reg;
            sx2_reg <= 64'(ux_next) * 64'(ux_next);
            sy2_reg <= 64'(uy_next) * 64'(uy_next);
            sz2_reg <= 64'(uz_next) * 64'(uz_next);
            r2_reg  <= 62'(radius_reg) * 62'(radius_reg);

            b3_reg  <= 52'(px2_reg) + 52'(py2_reg) + 52'(pz2_reg);
            ll3_reg <= 66'(sx2_reg) + 66'(sy2_reg) + 66'(sz2_reg);

            b4_reg  <= b3_reg;
            ll4_reg <= ll3_reg;
            aa4_reg <= 52'(ab_next[25:0]) * 52'(ab_next[25:0]);
            am4_reg <= 51'(ab_next[25:0]) * 51'(ab_next[50:26]);
            hh4_reg <= 50'(ab_next[50:26]) * 50'(ab_next[50:26]);

            b5_reg   <= b4_reg;
            pos5_reg <= {2'b00, hh4_reg, 52'd0} + {26'd0, am4_reg, 27'd0}
                      + {52'd0, aa4_reg} + {10'd0, r2_reg, 32'd0};
            neg5_reg <= {6'd0, ll4_reg, 32'd0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sv_reg[0] <= 1'b0;
        else if (en)
            sv_reg[0] <= v5_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            smiss_reg[0] <= neg5_reg > pos5_reg;
            sb_reg[0]    <= b5_reg;
            sdisc_reg[0] <= (neg5_reg > pos5_reg) ? '0 : pos5_reg - neg5_reg;
            sroot_reg[0] <= '0;
            srem_reg[0]  <= '0;
        end
    end

    for (genvar k = 0; k < SqN; k++)
    begin : g_sqrt
        logic [54:0]  rsh_next;
        logic [54:0]  trial_next;
        logic [54:0]  rem_next;
        logic [51:0]  root_next;

        always_comb
        begin
            rsh_next   = {srem_reg[k][52:0], sdisc_reg[k][103:102]};
            trial_next = {1'b0, sroot_reg[k], 2'b01};
            if (rsh_next >= trial_next)
            begin
                rem_next  = rsh_next - trial_next;
                root_next = {sroot_reg[k][50:0], 1'b1};
            end
            else
            begin
                rem_next  = rsh_next;
                root_next = {sroot_reg[k][50:0], 1'b0};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                sv_reg[k+1] <= 1'b0;
            else if (en)
                sv_reg[k+1] <= sv_reg[k];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                smiss_reg[k+1] <= smiss_reg[k];
                sb_reg[k+1]    <= sb_reg[k];
                sdisc_reg[k+1] <= {sdisc_reg[k][101:0], 2'b00};
                sroot_reg[k+1] <= root_next;
                srem_reg[k+1]  <= rem_next;
            end
        end
    end

    always_comb
    begin
        logic signed [53:0] far_t;
        logic signed [53:0] near_t;
        logic signed [53:0] dist_t;
        far_t  = $signed({2'b00, sroot_reg[SqN]}) - 54'(sb_reg[SqN]);
        near_t = -54'(sb_reg[SqN]) - $signed({2'b00, sroot_reg[SqN]});
        dist_t = near_t[53] ? far_t : near_t;
        hit_next  = !smiss_reg[SqN] && !far_t[53];
        dist_next = '0;
        if (hit_next)
        begin
            if (dist_t[52:47] != '0)
                dist_next = '1;
            else
                dist_next = dist_t[46:16];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vo_reg <= 1'b0;
        else if (en)
            vo_reg <= sv_reg[SqN];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hit_reg  <= hit_next;
            dist_reg <= dist_next;
        end
    end

    assign result.valid        = vo_reg;
    assign result.hit          = hit_reg;
    assign result.hit_distance = dist_reg;

    `RSI_ASSERT_SAME(a_miss_zero, vo_reg && !hit_reg, dist_reg == '0)
    `RSI_ASSERT_NEXT(a_stall_hold, !en, $stable(sv_reg[SqN]) && $stable(v5_reg))
    `RSI_ASSERT_SAME(a_root_rem, sv_reg[SqN], srem_reg[SqN] <= {2'b00, sroot_reg[SqN], 1'b0})
    `RSI_ASSERT_SAME(a_miss_disc, sv_reg[0] && smiss_reg[0], sdisc_reg[0] == '0)

endmodule
